>>> design/rtt_pkg.sv
`default_nettype none
package rtt_pkg;

	typedef enum logic [1:0] {
		MODE_ADD    = 2'd0,
		MODE_REMOVE = 2'd1,
		MODE_IGNORE = 2'd2,
		MODE_TICK   = 2'd3
	} mode_t;

	localparam logic [15:0] TIMEOUT_RESET = 16'd100;
	localparam logic [15:0] TIMER_MAX     = 16'hFFFF;

	typedef struct packed {
		logic [1:0]  mode;
		logic [31:0] session_id;
		logic [31:0] message_id;
		logic [7:0]  message_type;
	} req_t;

	typedef struct packed {
		logic        found;
		logic        overflow;
		logic        timed_out;
		logic [31:0] expired_session;
		logic [31:0] expired_message;
		logic [7:0]  expired_type;
	} rsp_t;

	typedef struct packed {
		logic load;    // capture the accepted request
		logic rd;      // read slot at rd_addr
		logic wr;      // write entry at wr_addr
		logic wr_new;  // write the request as a fresh entry, else write wr data
		logic mark;    // rewrite entry with ignored set
		logic bump;    // rewrite entry with timer advanced
		logic rd_last; // read the last slot for a swap
		logic move;    // capture the matched entry and its slot for a swap
	} dp_cmd_t;

	typedef struct packed {
		logic key_hit;
		logic sess_hit;
		logic expire;
	} dp_sts_t;

endpackage
`default_nettype wire

>>> design/rtt_datapath.sv
`default_nettype none
module rtt_datapath #(
	parameter int AW = 5
) (
	input  wire              clk,
	input  rtt_pkg::req_t    req,
	input  wire [15:0]       timeout_ticks,
	input  wire [AW-1:0]     rd_addr,
	input  wire [AW-1:0]     wr_addr,
	input  rtt_pkg::dp_cmd_t cmd,
	output rtt_pkg::dp_sts_t sts,
	output logic [31:0]      ent_session,
	output logic [31:0]      ent_message,
	output logic [7:0]       ent_type,
	output logic             ent_ignored
);
	import rtt_pkg::*;

	localparam int DEPTH = 1 << AW;

	typedef struct packed {
		logic [31:0] session;
		logic [31:0] message;
		logic [7:0]  mtype;
		logic [15:0] timer;
		logic        ignored;
	} entry_t;

	entry_t mem [DEPTH];
	entry_t rd_q;
	entry_t last_q;
	entry_t wdata;
	req_t   req_q;
	logic [15:0] tnext;

	always_ff @(posedge clk) begin
		if (cmd.rd || cmd.rd_last) begin
			rd_q <= mem[rd_addr];
		end
		if (cmd.wr) begin
			mem[wr_addr] <= wdata;
		end
	end

	// Hold a copy of the removed entry across the swap.
	always_ff @(posedge clk) begin
		if (cmd.move) begin
			last_q <= rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q <= req;
		end
	end

	always_comb begin
		tnext = (rd_q.timer < TIMER_MAX) ? rd_q.timer + 16'd1 : rd_q.timer;
		wdata = rd_q;
		if (cmd.wr_new) begin
			wdata = '{session: req.session_id, message: req.message_id,
				mtype: req.message_type, timer: 16'd0, ignored: 1'b0};
		end else if (cmd.mark) begin
			wdata.ignored = 1'b1;
		end else if (cmd.bump) begin
			wdata.timer = tnext;
		end else if (cmd.move) begin
			wdata = rd_q;
		end
	end

	assign sts.sess_hit = rd_q.session == req_q.session_id;
	assign sts.key_hit  = sts.sess_hit && rd_q.message == req_q.message_id;
	assign sts.expire   = tnext >= timeout_ticks;
	assign ent_session  = last_q.session;
	assign ent_message  = last_q.message;
	assign ent_type     = last_q.mtype;
	assign ent_ignored  = last_q.ignored;
endmodule
`default_nettype wire

>>> design/rtt_ctrl.sv
`default_nettype none
module rtt_ctrl #(
	parameter int AW = 5,
	parameter int DEPTH = 32
) (
	input  wire              clk,
	input  wire              arst_n,
	input  wire              in_valid,
	output logic             in_ready,
	input  rtt_pkg::req_t    req,
	output logic             out_valid,
	input  wire              out_ready,
	output rtt_pkg::rsp_t    rsp,
	input  rtt_pkg::dp_sts_t sts,
	input  wire [31:0]       ent_session,
	input  wire [31:0]       ent_message,
	input  wire [7:0]        ent_type,
	input  wire              ent_ignored,
	output rtt_pkg::dp_cmd_t cmd,
	output logic [AW-1:0]    rd_addr,
	output logic [AW-1:0]    wr_addr,
	output logic [AW:0]      count
);
	import rtt_pkg::*;

	localparam logic [AW:0] FULL = (AW+1)'(DEPTH);

	typedef enum logic [2:0] {
		S_IDLE, S_READ, S_CHECK, S_LAST, S_HOLD, S_MOVE, S_DONE
	} state_t;

	state_t      state_q;
	logic [AW:0] idx_q;
	logic [AW:0] count_q;
	logic        is_tick_q;
	rsp_t        rsp_q;
	req_t        req_q;
	mode_t       mode;

	assign mode     = mode_t'(req_q.mode);
	assign in_ready = state_q == S_IDLE;
	assign out_valid = state_q == S_DONE;
	assign rsp      = rsp_q;
	assign count    = count_q;
	assign rd_addr  = (state_q == S_CHECK || state_q == S_LAST) ?
		AW'(count_q - 1'b1) : idx_q[AW-1:0];

	always_comb begin
		cmd = '0;
		wr_addr = idx_q[AW-1:0];
		unique case (state_q)
			S_IDLE: begin
				cmd.load = in_valid;
				cmd.wr = in_valid && req.mode == MODE_ADD && count_q != FULL;
				cmd.wr_new = cmd.wr;
				wr_addr = count_q[AW-1:0];
			end
			S_READ:  cmd.rd = idx_q < count_q;
			S_CHECK: begin
				unique case (mode)
					MODE_IGNORE: begin
						cmd.wr = sts.sess_hit;
						cmd.mark = 1'b1;
					end
					MODE_TICK: begin
						cmd.wr = 1'b1;
						cmd.bump = 1'b1;
					end
					default: ;
				endcase
				// matched or expired entry copied out now; the current read holds it
				cmd.rd_last = 1'b1;
				cmd.move = (mode == MODE_REMOVE && sts.key_hit) ||
					(mode == MODE_TICK && sts.expire);
			end
			S_MOVE: begin
				cmd.wr = 1'b1;
				cmd.move = 1'b0;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			count_q <= '0;
			idx_q <= '0;
			is_tick_q <= 1'b0;
			req_q <= '0;
			rsp_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						req_q <= req;
						idx_q <= '0;
						if (req.mode == MODE_ADD) begin
							rsp_q <= '{found: count_q != FULL,
								overflow: count_q == FULL, timed_out: 1'b0,
								expired_session: '0, expired_message: '0,
								expired_type: '0};
							if (count_q != FULL) begin
								count_q <= count_q + 1'b1;
							end
							state_q <= S_DONE;
						end else begin
							rsp_q <= '0;
							state_q <= S_READ;
						end
					end
				end
				S_READ: state_q <= (idx_q < count_q) ? S_CHECK : S_DONE;
				S_CHECK: begin
					if (cmd.move) begin
						is_tick_q <= mode == MODE_TICK;
						state_q <= S_LAST;
					end else begin
						idx_q <= idx_q + 1'b1;
						state_q <= S_READ;
					end
				end
				S_LAST: state_q <= S_HOLD;
				S_HOLD: begin
					// last_q has the victim, rd_q already holds the last entry
					if (is_tick_q) begin
						rsp_q <= '{found: 1'b0, overflow: 1'b0,
							timed_out: !ent_ignored, expired_session: ent_session,
							expired_message: ent_message, expired_type: ent_type};
					end else begin
						rsp_q <= '{found: 1'b1, overflow: 1'b0, timed_out: 1'b0,
							expired_session: '0, expired_message: '0,
							expired_type: '0};
					end
					state_q <= S_MOVE;
				end
				S_MOVE: begin
					count_q <= count_q - 1'b1;
					state_q <= S_DONE;
				end
				S_DONE: if (out_ready) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

>>> design/rtt_swap.sv
`default_nettype none
module rtt_swap #(
	parameter int AW = 5
) (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           load,
	input  wire [AW-1:0]  slot,
	output logic [AW-1:0] slot_q
);
	// Remember the freed slot while the last entry is fetched.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else if (load) begin
			slot_q <= slot;
		end
	end
endmodule
`default_nettype wire

>>> design/reply_timeout_tracker_top.sv
`default_nettype none
// Table of up to TABLE_DEPTH outstanding requests. An add writes the next free
// slot directly; remove, ignore-session and tick scan the filled slots in
// turn, a READ step then a CHECK step per slot, and the block takes no new
// request until the result has been taken on out_ready. A removal moves the
// last entry into the freed slot. No clearing pass: only slots below the fill
// count are ever read.
module reply_timeout_tracker_top #(
	parameter int TABLE_DEPTH = 32
) (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	input  rtt_pkg::req_t      in_data,
	output logic               out_valid,
	input  wire                out_ready,
	output rtt_pkg::rsp_t      out_data,
	input  wire                cfg_we,
	input  wire [15:0]         cfg_wdata
);
	import rtt_pkg::*;

	localparam int AW = $clog2(TABLE_DEPTH);

	logic [15:0]   timeout_q;
	dp_cmd_t       cmd;
	dp_cmd_t       dcmd;
	dp_sts_t       sts;
	logic [AW-1:0] rd_addr, wr_addr, slot_q, dwr;
	logic [AW:0]   count;
	logic [31:0]   ent_session, ent_message;
	logic [7:0]    ent_type;
	logic          ent_ignored;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			timeout_q <= TIMEOUT_RESET;
		end else if (cfg_we) begin
			timeout_q <= cfg_wdata;
		end
	end

	rtt_ctrl #(.AW(AW), .DEPTH(TABLE_DEPTH)) u_ctrl (
		.clk, .arst_n, .in_valid, .in_ready, .req(in_data),
		.out_valid, .out_ready, .rsp(out_data), .sts,
		.ent_session, .ent_message, .ent_type, .ent_ignored,
		.cmd, .rd_addr, .wr_addr, .count
	);

	rtt_swap #(.AW(AW)) u_swap (
		.clk, .arst_n, .load(cmd.move), .slot(wr_addr), .slot_q
	);

	// The move write targets the freed slot; in the HOLD step the held
	// entry is the victim and the fresh read is the last entry.
	always_comb begin
		dcmd = cmd;
		dwr = wr_addr;
		if (cmd.wr && !cmd.wr_new && !cmd.mark && !cmd.bump) begin
			dwr = slot_q;
		end
	end

	rtt_datapath #(.AW(AW)) u_dp (
		.clk, .req(in_data), .timeout_ticks(timeout_q),
		.rd_addr, .wr_addr(dwr), .cmd(dcmd), .sts,
		.ent_session, .ent_message, .ent_type, .ent_ignored
	);

`ifndef NO_ASSERTIONS
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		count <= (AW+1)'(TABLE_DEPTH)) else $error("count over depth");
	a_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(out_data.found && out_data.overflow))
		else $error("found with overflow");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready) else $error("accept while result pending");
`endif
endmodule
`default_nettype wire

>>> sim/timeout_checker.sv
`default_nettype none
module timeout_checker #(
	parameter int TABLE_DEPTH = 32
) (
	input  wire            clk,
	input  wire            arst_n,
	input  wire            in_valid,
	input  wire            in_ready,
	input  rtt_pkg::req_t  in_data,
	input  wire            out_valid,
	input  wire            out_ready,
	input  rtt_pkg::rsp_t  out_data,
	input  wire            cfg_we,
	input  wire [15:0]     cfg_wdata,
	output int             errors,
	output int             pending
);
	import rtt_pkg::*;

	logic [31:0] tbl_session [TABLE_DEPTH];
	logic [31:0] tbl_message [TABLE_DEPTH];
	logic [7:0]  tbl_type    [TABLE_DEPTH];
	logic [15:0] tbl_timer   [TABLE_DEPTH];
	logic        tbl_ignored [TABLE_DEPTH];
	int          fill;
	logic [15:0] timeout_limit;
	rsp_t        replies_due [$];

	initial begin
		errors = 0;
	end

	assign pending = replies_due.size();

	task automatic report_mismatch(input string field, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: %s got %h want %h", $realtime, field, got, want);
		errors++;
	endtask

	// close the gap left at slot by moving the last entry into it
	task automatic free_slot(input int slot);
		int last;
		last = fill - 1;
		if (slot != last) begin
			tbl_session[slot] = tbl_session[last];
			tbl_message[slot] = tbl_message[last];
			tbl_type[slot]    = tbl_type[last];
			tbl_timer[slot]   = tbl_timer[last];
			tbl_ignored[slot] = tbl_ignored[last];
		end
		fill = last;
	endtask

	task automatic predict_reply(input req_t req, output rsp_t rsp);
		rsp = '0;
		case (mode_t'(req.mode))
			MODE_ADD: begin
				if (fill < TABLE_DEPTH) begin
					tbl_session[fill] = req.session_id;
					tbl_message[fill] = req.message_id;
					tbl_type[fill]    = req.message_type;
					tbl_timer[fill]   = '0;
					tbl_ignored[fill] = 1'b0;
					fill++;
					rsp.found = 1'b1;
				end else begin
					rsp.overflow = 1'b1;
				end
			end
			MODE_REMOVE: begin
				for (int i = 0; i < fill; i++) begin
					if (tbl_session[i] == req.session_id &&
							tbl_message[i] == req.message_id) begin
						free_slot(i);
						rsp.found = 1'b1;
						break;
					end
				end
			end
			MODE_IGNORE: begin
				for (int i = 0; i < fill; i++)
					if (tbl_session[i] == req.session_id)
						tbl_ignored[i] = 1'b1;
			end
			MODE_TICK: begin
				for (int i = 0; i < fill; i++) begin
					if (tbl_timer[i] != TIMER_MAX)
						tbl_timer[i] = tbl_timer[i] + 16'd1;
					if (tbl_timer[i] >= timeout_limit) begin
						rsp.timed_out       = !tbl_ignored[i];
						rsp.expired_session = tbl_session[i];
						rsp.expired_message = tbl_message[i];
						rsp.expired_type    = tbl_type[i];
						free_slot(i);
						break;
					end
				end
			end
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t want;
		if (!arst_n) begin
			fill = 0;
			timeout_limit = TIMEOUT_RESET;
			replies_due.delete();
		end else begin
			if (cfg_we)
				timeout_limit = cfg_wdata;
			if (in_valid && in_ready) begin
				predict_reply(in_data, want);
				replies_due.insert(replies_due.size(), want);
			end
			if (out_valid && out_ready) begin
				if (replies_due.size() == 0) begin
					report_mismatch("unexpected transfer", 32'd0, 32'd0);
				end else begin
					want = replies_due.pop_front();
					if (out_data.found !== want.found)
						report_mismatch("found", 32'(out_data.found), 32'(want.found));
					if (out_data.overflow !== want.overflow)
						report_mismatch("overflow", 32'(out_data.overflow),
							32'(want.overflow));
					if (out_data.timed_out !== want.timed_out)
						report_mismatch("timed_out", 32'(out_data.timed_out),
							32'(want.timed_out));
					if (out_data.expired_session !== want.expired_session)
						report_mismatch("expired_session", out_data.expired_session,
							want.expired_session);
					if (out_data.expired_message !== want.expired_message)
						report_mismatch("expired_message", out_data.expired_message,
							want.expired_message);
					if (out_data.expired_type !== want.expired_type)
						report_mismatch("expired_type", 32'(out_data.expired_type),
							32'(want.expired_type));
				end
			end
		end
	end
endmodule
`default_nettype wire

>>> sim/testbench.sv
`default_nettype none
module testbench;
	import rtt_pkg::*;

	localparam int WATCHDOG_LIMIT = 5000;
	localparam int SETTLE_CYCLES  = 100;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	req_t        in_data = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	rsp_t        out_data;
	logic        cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	int          errors;
	int          pending;
	logic        calm = 1'b0;
	logic        done = 1'b0;

	logic [31:0] session_pool [4] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h5A5A_0003};
	logic [63:0] added_keys [$];

	reply_timeout_tracker_top uut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
	);

	timeout_checker check (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.errors(errors), .pending(pending)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	task automatic send_request(input mode_t mode, input logic [31:0] sess,
			input logic [31:0] msg, input logic [7:0] kind);
		in_valid <= 1'b1;
		in_data  <= '{mode: mode, session_id: sess, message_id: msg, message_type: kind};
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		if (mode == MODE_ADD) begin
			added_keys.insert(added_keys.size(), {msg, sess});
			if (added_keys.size() > 64) void'(added_keys.pop_front());
		end
		if (!calm && $urandom_range(0, 99) < 16) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	// drain, let the block settle, then change the timeout
	task automatic set_timeout(input logic [15:0] ticks);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= ticks;
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic random_request(input int add_weight);
		int          pick;
		logic [31:0] sess;
		logic [31:0] msg;
		pick = $urandom_range(0, 99);
		sess = ($urandom_range(0, 4) == 0) ? $urandom : session_pool[$urandom_range(0, 3)];
		msg  = ($urandom_range(0, 4) == 0) ? $urandom : $urandom_range(0, 5);
		if (pick < add_weight) begin
			send_request(MODE_ADD, sess, msg, 8'($urandom_range(0, 255)));
		end else if (pick < add_weight + 25) begin
			if (added_keys.size() != 0 && $urandom_range(0, 9) < 7)
				{msg, sess} = added_keys[$urandom_range(0, added_keys.size() - 1)];
			send_request(MODE_REMOVE, sess, msg, 8'($urandom_range(0, 255)));
		end else if (pick < add_weight + 33) begin
			send_request(MODE_IGNORE, sess, msg, 8'($urandom_range(0, 255)));
		end else begin
			send_request(MODE_TICK, sess, msg, 8'($urandom_range(0, 255)));
		end
	endtask

	// stimulus
	initial begin
		logic [15:0] phase_ticks [8] = '{16'd65535, 16'd3, 16'd0, 16'd1, 16'd12,
			16'd100, 16'd40, 16'd5};
		int          phase_adds  [8] = '{60, 30, 35, 30, 45, 55, 40, 35};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		set_timeout(16'd2);
		send_request(MODE_REMOVE, 32'h0, 32'h0, 8'h00);
		send_request(MODE_TICK, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF);
		send_request(MODE_ADD, 32'h0, 32'hFFFF_FFFF, 8'h00);
		send_request(MODE_ADD, 32'hFFFF_FFFF, 32'h0, 8'hFF);
		send_request(MODE_ADD, 32'hFFFF_FFFF, 32'h0, 8'hA5);
		send_request(MODE_ADD, 32'h1234_5678, 32'h9ABC_DEF0, 8'h5A);
		send_request(MODE_REMOVE, 32'hFFFF_FFFF, 32'h0, 8'h00);
		send_request(MODE_REMOVE, 32'h1234_5678, 32'h0, 8'h00);
		send_request(MODE_IGNORE, 32'h0, 32'h0, 8'h00);
		send_request(MODE_TICK, 32'h0, 32'h0, 8'h00);
		send_request(MODE_TICK, 32'h0, 32'h0, 8'h00);
		send_request(MODE_TICK, 32'h0, 32'h0, 8'h00);
		send_request(MODE_TICK, 32'h0, 32'h0, 8'h00);
		send_request(MODE_TICK, 32'h0, 32'h0, 8'h00);
		send_request(MODE_REMOVE, 32'h1234_5678, 32'h9ABC_DEF0, 8'h00);

		foreach (phase_ticks[p]) begin
			set_timeout(phase_ticks[p]);
			for (int n = 0; n < 155; n++) begin
				calm <= (p == 4 && n >= 40 && n < 120);
				random_request(phase_adds[p]);
			end
			calm <= 1'b0;
		end

		in_valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		done <= 1'b1;
		if (errors == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// result side: random back-pressure plus one long hold-off
	initial begin
		int cycle;
		cycle = 0;
		forever begin
			@(posedge clk);
			cycle++;
			if (cycle >= 6000 && cycle < 6400)
				out_ready <= 1'b0;
			else
				out_ready <= calm || $urandom_range(0, 99) >= 16;
		end
	end

	initial begin
		int quiet;
		quiet = 0;
		while (quiet < WATCHDOG_LIMIT || done) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("SCOREBOARD MISMATCH");
		$finish;
	end
endmodule
`default_nettype wire
